// ===== hw/rtl/bohl_pkg.sv =====
// Shared types and constants for the bounded ordered handle list.
// Used by the channel interfaces, the list cells, the match scanner and the core.
package bohl_pkg;

    // Field widths fixed by the channel payloads
    localparam int REQ_TYPE_W   = 3;
    localparam int POSITION_W   = 7;
    localparam int HANDLE_W     = 32;
    localparam int FOUND_W      = 7;
    localparam int COUNT_W      = 7;

    // Widest index and count carried to the cells (list depth up to 256)
    localparam int IDX_MAX_W    = 8;
    localparam int CNT_MAX_W    = 9;

    // Match bits examined per scan cycle
    localparam int SCAN_GROUP   = 8;

    // Index reported when a find has no hit
    localparam logic signed [FOUND_W-1:0] FOUND_NONE = -7'sd1;

    // Request kinds
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_GET          = 3'd0,
        REQ_SET          = 3'd1,
        REQ_INSERT_AT    = 3'd2,
        REQ_APPEND       = 3'd3,
        REQ_REMOVE_AT    = 3'd4,
        REQ_REMOVE_VALUE = 3'd5,
        REQ_POP          = 3'd6,
        REQ_FIND         = 3'd7
    } req_kind_t;

    // Operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_COMPARE
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   at;
        logic [CNT_MAX_W-1:0]   limit;
    } cell_ctl_t;

    // Core sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } core_state_t;

endpackage

// ===== hw/rtl/bohl_req_if.sv =====
// Request channel: valid/ready handshake with the request payload.
// Depends on bohl_pkg for the field widths.
interface bohl_req_if import bohl_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [POSITION_W-1:0] position;
    logic [HANDLE_W-1:0]   handle_in;

    modport source (output valid, output req_type, output position, output handle_in,
                    input ready);
    modport sink   (input valid, input req_type, input position, input handle_in,
                    output ready);

endinterface

// ===== hw/rtl/bohl_rsp_if.sv =====
// Response channel: valid/ready handshake with the result payload.
// Depends on bohl_pkg for the field widths.
interface bohl_rsp_if import bohl_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [HANDLE_W-1:0]        handle_out;
    logic signed [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]         entry_count;
    logic                       can_add;

    modport source (output valid, output ok, output handle_out, output found_index,
                    output entry_count, output can_add, input ready);
    modport sink   (input valid, input ok, input handle_out, input found_index,
                    input entry_count, input can_add, output ready);

endinterface

// ===== hw/rtl/bohl_cell.sv =====
// One list cell: holds a single handle and trades it with its neighbors.
// Depends on bohl_pkg for the cell control struct.
module bohl_cell import bohl_pkg::*; #(
    parameter int HANDLE_BITS = 32,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctl_t              ctl,
    input  logic [HANDLE_BITS-1:0] data_in,
    input  logic [HANDLE_BITS-1:0] below_q,
    input  logic [HANDLE_BITS-1:0] above_q,
    output logic [HANDLE_BITS-1:0] entry_q,
    output logic                   match_q
);

    localparam logic [IDX_MAX_W-1:0] MY_AT  = IDX_MAX_W'(INDEX);
    localparam logic [CNT_MAX_W-1:0] MY_CNT = CNT_MAX_W'(INDEX);

    logic [HANDLE_BITS-1:0] entry_reg;
    logic [HANDLE_BITS-1:0] entry_next;
    logic                   match_reg;
    logic                   match_next;

    // Pick the new entry value from the broadcast operation
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            CELL_WRITE:
            begin
                if (MY_AT == ctl.at)
                begin
                    entry_next = data_in;
                end
            end
            CELL_SHIFT_UP:
            begin
                if (MY_AT > ctl.at)
                begin
                    entry_next = below_q;
                end
                else if (MY_AT == ctl.at)
                begin
                    entry_next = data_in;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                if (MY_AT >= ctl.at)
                begin
                    entry_next = above_q;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Compare against the request handle, only inside the filled part
    always_comb
    begin
        match_next = match_reg;
        if (ctl.op == CELL_COMPARE)
        begin
            match_next = (MY_CNT < ctl.limit) && (entry_reg == data_in);
        end
    end

    // Hold the handle; it carries no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry_q = entry_reg;
    assign match_q = match_reg;

endmodule

// ===== hw/rtl/bohl_match_scan.sv =====
// First-match finder: examines one group of cell match bits per cycle.
// Depends on bohl_pkg for the group size.
module bohl_match_scan import bohl_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic [DEPTH-1:0]                              match_vec,
    input  logic [((DEPTH+SCAN_GROUP-1)/SCAN_GROUP > 1 ?
                   $clog2((DEPTH+SCAN_GROUP-1)/SCAN_GROUP) : 1)-1:0] grp,
    output logic                                          hit,
    output logic [$clog2(DEPTH)-1:0]                      idx
);

    localparam int NGRP  = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int PAD_W = NGRP * SCAN_GROUP;
    localparam int LOC_W = $clog2(SCAN_GROUP);
    localparam int IDX_W = $clog2(DEPTH);

    logic [PAD_W-1:0]      match_pad;
    logic [SCAN_GROUP-1:0] slice;
    logic [LOC_W-1:0]      loc;

    assign match_pad = PAD_W'(match_vec);
    assign slice     = match_pad[grp*SCAN_GROUP +: SCAN_GROUP];

    // Pick the lowest set bit of the current group
    always_comb
    begin
        loc = '0;
        for (int i = SCAN_GROUP - 1; i >= 0; i--)
        begin
            if (slice[i])
            begin
                loc = LOC_W'(i);
            end
        end
    end

    assign hit = |slice;
    assign idx = IDX_W'({grp, loc});

endmodule

// ===== hw/rtl/bounded_ordered_handle_list_core.sv =====
// Bounded ordered handle list over a row of DEPTH register cells; one request at a time.
// get, set, insert_at, append, remove_at, pop: the request is held, then the result is registered
// once the response slot is free; the row shifts or writes at the clock edge that loads the result.
// find, remove_value: compare, scan the match bits in groups of 8 (up to ceil(DEPTH/8) groups,
// stopping at the first hit), then finish. A new request is taken only once the core is idle again.
// Reset clears the count and control state; handles are not cleared and need no pass.
module bounded_ordered_handle_list_core import bohl_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    bohl_req_if.sink   req,
    bohl_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam int NGRP  = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(NGRP - 1);

    core_state_t state_reg;
    core_state_t state_next;

    // Held request
    req_kind_t              kind_reg;
    logic [POSITION_W-1:0]  pos_reg;
    logic [HANDLE_BITS-1:0] h_reg;

    // List count and search progress
    logic [CNT_W-1:0]       fill_count_reg;
    logic [CNT_W-1:0]       fill_next;
    logic [GRP_W-1:0]       grp_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       idx_reg;

    // Result register
    logic                      out_valid_reg;
    logic                      out_ok_reg;
    logic [HANDLE_W-1:0]       out_handle_reg;
    logic signed [FOUND_W-1:0] out_fidx_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_can_add_reg;

    // Row signals
    cell_ctl_t              ctl;
    logic [HANDLE_BITS-1:0] entry_q [DEPTH];
    logic [DEPTH-1:0]       match_vec;

    // Sequencer outputs
    logic                   slot_free;
    logic                   res_load;
    logic                   res_ok;
    logic [HANDLE_BITS-1:0] res_h;
    logic signed [FOUND_W-1:0] res_fidx;

    // Request checks
    logic [CMP_W-1:0]       pos_x;
    logic [CMP_W-1:0]       fill_x;
    logic                   in_range;
    logic                   ins_range;
    logic                   not_full;
    logic                   not_empty;
    logic [IDX_W-1:0]       rd_idx;
    logic [HANDLE_BITS-1:0] rd_data;

    logic                   scan_hit;
    logic [IDX_W-1:0]       scan_idx;
    logic                   scan_done;

    // Row of cells
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [HANDLE_BITS-1:0] below;
        logic [HANDLE_BITS-1:0] above;

        if (k == 0)
        begin : g_first
            assign below = entry_q[k];
        end
        else
        begin : g_inner_lo
            assign below = entry_q[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign above = entry_q[k];
        end
        else
        begin : g_inner_hi
            assign above = entry_q[k+1];
        end

        bohl_cell #(
            .HANDLE_BITS (HANDLE_BITS),
            .INDEX       (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .data_in (h_reg),
            .below_q (below),
            .above_q (above),
            .entry_q (entry_q[k]),
            .match_q (match_vec[k])
        );
    end

    bohl_match_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .match_vec (match_vec),
        .grp       (grp_reg),
        .hit       (scan_hit),
        .idx       (scan_idx)
    );

    assign scan_done = scan_hit || (grp_reg == GRP_LAST);

    // Bounds checks on the held request
    assign pos_x     = CMP_W'(pos_reg);
    assign fill_x    = CMP_W'(fill_count_reg);
    assign in_range  = pos_x < fill_x;
    assign ins_range = pos_x <= fill_x;
    assign not_full  = fill_count_reg < CNT_W'(DEPTH);
    assign not_empty = fill_count_reg != '0;
    assign rd_idx    = (kind_reg == REQ_POP) ? IDX_W'(fill_count_reg - 1'b1)
                                             : IDX_W'(pos_reg);
    assign rd_data   = entry_q[rd_idx];

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (kind_reg == REQ_FIND || kind_reg == REQ_REMOVE_VALUE)
                begin
                    state_next = ST_SCAN;
                end
                else if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Row control, count update and result
    always_comb
    begin
        ctl.op    = CELL_HOLD;
        ctl.at    = '0;
        ctl.limit = CNT_MAX_W'(fill_count_reg);
        fill_next = fill_count_reg;
        res_load  = 1'b0;
        res_ok    = 1'b0;
        res_h     = '0;
        res_fidx  = FOUND_NONE;
        case (state_reg)
            ST_EXEC:
            begin
                if (kind_reg == REQ_FIND || kind_reg == REQ_REMOVE_VALUE)
                begin
                    ctl.op = CELL_COMPARE;
                end
                else if (slot_free)
                begin
                    res_load = 1'b1;
                    case (kind_reg)
                        REQ_GET:
                        begin
                            res_ok = in_range;
                            res_h  = rd_data;
                        end
                        REQ_SET:
                        begin
                            res_ok = in_range;
                            res_h  = h_reg;
                            if (in_range)
                            begin
                                ctl.op = CELL_WRITE;
                                ctl.at = IDX_MAX_W'(pos_reg);
                            end
                        end
                        REQ_INSERT_AT:
                        begin
                            res_ok = not_full && ins_range;
                            res_h  = h_reg;
                            if (not_full && ins_range)
                            begin
                                ctl.op    = CELL_SHIFT_UP;
                                ctl.at    = IDX_MAX_W'(pos_reg);
                                fill_next = CNT_W'(fill_count_reg + 1'b1);
                            end
                        end
                        REQ_APPEND:
                        begin
                            res_ok = not_full;
                            res_h  = h_reg;
                            if (not_full)
                            begin
                                ctl.op    = CELL_WRITE;
                                ctl.at    = IDX_MAX_W'(fill_count_reg);
                                fill_next = CNT_W'(fill_count_reg + 1'b1);
                            end
                        end
                        REQ_REMOVE_AT:
                        begin
                            res_ok = in_range;
                            res_h  = rd_data;
                            if (in_range)
                            begin
                                ctl.op    = CELL_SHIFT_DOWN;
                                ctl.at    = IDX_MAX_W'(pos_reg);
                                fill_next = CNT_W'(fill_count_reg - 1'b1);
                            end
                        end
                        REQ_POP:
                        begin
                            res_ok = not_empty;
                            res_h  = rd_data;
                            if (not_empty)
                            begin
                                fill_next = CNT_W'(fill_count_reg - 1'b1);
                            end
                        end
                        default:
                        begin
                            res_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    res_load = 1'b1;
                    res_ok   = hit_reg;
                    res_h    = h_reg;
                    if (kind_reg == REQ_FIND)
                    begin
                        if (hit_reg)
                        begin
                            res_fidx = FOUND_W'(idx_reg);
                        end
                    end
                    else if (hit_reg)
                    begin
                        ctl.op    = CELL_SHIFT_DOWN;
                        ctl.at    = IDX_MAX_W'(idx_reg);
                        fill_next = CNT_W'(fill_count_reg - 1'b1);
                    end
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            grp_reg        <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_next;
            // Advance the scan one group per cycle, capture the outcome when done
            if (state_reg == ST_EXEC)
            begin
                grp_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (scan_done)
                begin
                    hit_reg <= scan_hit;
                end
                else
                begin
                    grp_reg <= GRP_W'(grp_reg + 1'b1);
                end
            end
            // Hold the result until the sink takes the transfer
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg <= req_kind_t'(req.req_type);
            pos_reg  <= req.position;
            h_reg    <= HANDLE_BITS'(req.handle_in);
        end
        if (state_reg == ST_SCAN && scan_done)
        begin
            idx_reg <= scan_idx;
        end
        if (res_load)
        begin
            out_ok_reg      <= res_ok;
            out_handle_reg  <= res_ok ? HANDLE_W'(res_h) : '0;
            out_fidx_reg    <= res_fidx;
            out_count_reg   <= COUNT_W'(fill_next);
            out_can_add_reg <= fill_next < CNT_W'(DEPTH);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.handle_out  = out_handle_reg;
    assign rsp.found_index = out_fidx_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.can_add     = out_can_add_reg;

endmodule
